// ===== rtl/wfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wfs_pkg;

	// field widths at the ports
	localparam int IN_W   = 24;
	localparam int MEAN_W = 32;
	localparam int STD_W  = 31;
	localparam int DIV_W  = 17;

	// arithmetic widths
	localparam int MEAN_MAG_W = 32;
	localparam int MUL_W      = 32;
	localparam int MUL_STEPS  = 32;
	localparam int ROOT_IN_W  = 62;
	localparam int ROOT_STEPS = 31;
	localparam int RREM_W     = 33;

	localparam logic [MEAN_MAG_W-1:0] MEAN_POS_MAG = 32'h7FFF_FFFF;
	localparam logic [MEAN_MAG_W-1:0] MEAN_NEG_MAG = 32'h8000_0000;

	// defaults
	localparam int DEF_MAX_SAMPLES = 2048;
	localparam int DEF_SAMPLE_BITS = 24;
	localparam logic [DIV_W-1:0] DIV_RESET = 17'd2048;

	// register file
	localparam int APB_DATA_W = 32;
	localparam int PADDR_W    = 3;
	localparam int REG_IDX_W  = 1;
	localparam logic [REG_IDX_W-1:0] REG_MEAN_DIVISOR = 1'b0;

	function automatic int count_width(input int max_samples);
		return $clog2(max_samples + 1);
	endfunction

	function automatic int acc_width(input int max_samples);
		return count_width(max_samples) + 2 * MEAN_MAG_W - 1;
	endfunction

	typedef enum logic [3:0] {
		ST_ACCUM,
		ST_DRAIN,
		ST_MEAN_LD,
		ST_MEAN_DIV,
		ST_SQ_LD,
		ST_SQ_MUL,
		ST_N_LD,
		ST_N_MUL,
		ST_X_LD,
		ST_X_MUL,
		ST_VAR_LD,
		ST_VAR_DIV,
		ST_ROOT_LD,
		ST_ROOT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic div_load_mean;
		logic div_load_var;
		logic div_step;
		logic mul_load_sq;
		logic mul_load_n;
		logic mul_load_x;
		logic mul_step;
		logic mul_sub;
		logic root_load;
		logic root_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic last_taken;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/wfs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface wfs_sample_if import wfs_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [IN_W-1:0] sample;
	logic                   last;

	modport source (output valid, output sample, output last, input ready);
	modport sink (input valid, input sample, input last, output ready);
endinterface

interface wfs_result_if import wfs_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [MEAN_W-1:0] mean;
	logic [STD_W-1:0]         std_dev;
	logic signed [IN_W-1:0]   minimum;
	logic signed [IN_W-1:0]   maximum;
	logic [IN_W-1:0]          peak_to_peak;
	logic                     overflow;

	modport source (output valid, output mean, output std_dev, output minimum,
		output maximum, output peak_to_peak, output overflow, input ready);
	modport sink (input valid, input mean, input std_dev, input minimum,
		input maximum, input peak_to_peak, input overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/wfs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wfs_ctrl import wfs_pkg::*; #(
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
	input  wire  clk,
	input  wire  arst_n,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam int AW     = acc_width(MAX_SAMPLES);
	localparam int STEP_W = $clog2(AW);
	localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(AW - 1);
	localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(MUL_STEPS - 1);
	localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_STEPS - 1);

	state_t state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic step_clr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (step_clr) begin
				step_q <= '0;
			end else begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		step_clr = 1'b0;
		unique case (state_q)
			ST_ACCUM: begin
				cmd.in_ready = 1'b1;
				step_clr     = 1'b1;
				if (sts.last_taken) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				step_clr = 1'b1;
				state_d  = ST_MEAN_LD;
			end
			ST_MEAN_LD: begin
				cmd.div_load_mean = 1'b1;
				step_clr          = 1'b1;
				state_d           = ST_MEAN_DIV;
			end
			ST_MEAN_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == DIV_LAST) begin
					state_d = ST_SQ_LD;
				end
			end
			ST_SQ_LD: begin
				cmd.mul_load_sq = 1'b1;
				step_clr        = 1'b1;
				state_d         = ST_SQ_MUL;
			end
			ST_SQ_MUL: begin
				cmd.mul_step = 1'b1;
				if (step_q == MUL_LAST) begin
					state_d = ST_N_LD;
				end
			end
			ST_N_LD: begin
				cmd.mul_load_n = 1'b1;
				step_clr       = 1'b1;
				state_d        = ST_N_MUL;
			end
			ST_N_MUL: begin
				cmd.mul_step = 1'b1;
				if (step_q == MUL_LAST) begin
					state_d = ST_X_LD;
				end
			end
			ST_X_LD: begin
				cmd.mul_load_x = 1'b1;
				step_clr       = 1'b1;
				state_d        = ST_X_MUL;
			end
			ST_X_MUL: begin
				cmd.mul_step = 1'b1;
				cmd.mul_sub  = 1'b1;
				if (step_q == MUL_LAST) begin
					state_d = ST_VAR_LD;
				end
			end
			ST_VAR_LD: begin
				cmd.div_load_var = 1'b1;
				step_clr         = 1'b1;
				state_d          = ST_VAR_DIV;
			end
			ST_VAR_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == DIV_LAST) begin
					state_d = ST_ROOT_LD;
				end
			end
			ST_ROOT_LD: begin
				cmd.root_load = 1'b1;
				step_clr      = 1'b1;
				state_d       = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (step_q == ROOT_LAST) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				step_clr = 1'b1;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_ACCUM;
				end
			end
			default: begin
				state_d = ST_ACCUM;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/wfs_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wfs_dpath import wfs_pkg::*; #(
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire [DIV_W-1:0]   mean_divisor,
	input  cmd_t              cmd,
	output sts_t              sts,
	wfs_sample_if.sink        samples,
	wfs_result_if.source      results
);

	localparam int SB = SAMPLE_BITS;
	localparam int CW = count_width(MAX_SAMPLES);
	localparam int SW = SB + CW;
	localparam int QW = 2 * SB - 2 + CW;
	localparam int AW = acc_width(MAX_SAMPLES);
	localparam int RW = RREM_W + 2;

	localparam logic signed [SB-1:0] MIN_RESET = {1'b0, {(SB - 1){1'b1}}};
	localparam logic signed [SB-1:0] MAX_RESET = {1'b1, {(SB - 1){1'b0}}};

	// sample intake
	logic                   accept;
	logic                   take;
	logic signed [SB-1:0]   x_in;
	logic signed [2*SB-1:0] x_sq;

	logic                   valid_s1;
	logic                   take_s1;
	logic signed [SB-1:0]   x_s1;
	logic [2*SB-2:0]        sq_s1;

	// accumulators
	logic [CW-1:0]        count_q;
	logic signed [SW-1:0] sum_q;
	logic [QW-1:0]        sq_q;
	logic signed [SB-1:0] min_q;
	logic signed [SB-1:0] max_q;
	logic                 drop_q;

	// divider
	logic [AW-1:0]    dvd_q;
	logic [DIV_W:0]   rem_q;
	logic [DIV_W-1:0] dsr_q;
	logic [DIV_W:0]   div_cat;
	logic [DIV_W+1:0] div_trial;
	logic             div_borrow;

	// mean
	logic                       sum_neg;
	logic [SW-1:0]              sum_mag;
	logic [AW-1:0]              mag_lim;
	logic [MEAN_MAG_W-1:0]      am_d;
	logic [MEAN_MAG_W-1:0]      am_q;
	logic signed [MEAN_W-1:0]   mean_q;

	// shift-add multiplier
	logic [AW-1:0]    acc_q;
	logic [AW-1:0]    mcand_q;
	logic [MUL_W-1:0] mplier_q;

	// square root
	logic [ROOT_IN_W-1:0] rad_q;
	logic [RREM_W-1:0]    rrem_q;
	logic [STD_W-1:0]     root_q;
	logic                 root_sat_q;
	logic [RW-1:0]        root_cur;
	logic [RW-1:0]        root_trial;

	// result register
	logic                     res_valid_q;
	logic signed [MEAN_W-1:0] res_mean_q;
	logic [STD_W-1:0]         res_std_q;
	logic signed [IN_W-1:0]   res_min_q;
	logic signed [IN_W-1:0]   res_max_q;
	logic [IN_W-1:0]          res_pp_q;
	logic                     res_ovf_q;

	assign samples.ready = cmd.in_ready;
	assign accept        = samples.valid & cmd.in_ready;
	assign take          = count_q < CW'(MAX_SAMPLES);
	assign x_in          = $signed(samples.sample[SB-1:0]);
	assign x_sq          = x_in * x_in;

	assign sts.last_taken = accept & samples.last;
	assign sts.out_free   = ~res_valid_q | results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1    <= x_in;
			sq_s1   <= x_sq[2*SB-2:0];
			take_s1 <= take;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			sq_q    <= '0;
			min_q   <= MIN_RESET;
			max_q   <= MAX_RESET;
			drop_q  <= 1'b0;
		end else if (cmd.emit) begin
			count_q <= '0;
			sum_q   <= '0;
			sq_q    <= '0;
			min_q   <= MIN_RESET;
			max_q   <= MAX_RESET;
			drop_q  <= 1'b0;
		end else begin
			if (accept) begin
				if (take) begin
					count_q <= count_q + CW'(1);
				end else begin
					drop_q <= 1'b1;
				end
			end
			if (valid_s1 && take_s1) begin
				sum_q <= sum_q + SW'(x_s1);
				sq_q  <= sq_q + QW'(sq_s1);
				if (x_s1 < min_q) begin
					min_q <= x_s1;
				end
				if (x_s1 > max_q) begin
					max_q <= x_s1;
				end
			end
		end
	end

	// restoring divider, one quotient bit per cycle
	assign div_cat    = {rem_q[DIV_W-1:0], dvd_q[AW-1]};
	assign div_trial  = {1'b0, div_cat} - {2'b00, dsr_q};
	assign div_borrow = div_trial[DIV_W+1];

	assign sum_neg = sum_q[SW-1];
	assign sum_mag = sum_neg ? $unsigned(-sum_q) : $unsigned(sum_q);
	assign mag_lim = AW'(sum_neg ? MEAN_NEG_MAG : MEAN_POS_MAG);
	assign am_d    = (dvd_q > mag_lim) ? mag_lim[MEAN_MAG_W-1:0] : dvd_q[MEAN_MAG_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.div_load_mean) begin
			dvd_q <= AW'(sum_mag);
			rem_q <= '0;
			dsr_q <= (mean_divisor == '0) ? DIV_W'(1) : mean_divisor;
		end else if (cmd.div_load_var) begin
			dvd_q <= acc_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[AW-2:0], ~div_borrow};
			rem_q <= div_borrow ? div_cat : div_trial[DIV_W:0];
		end
	end

	// shift-add multiplier accumulating into the variance
	always_ff @(posedge clk) begin
		if (cmd.mul_load_sq) begin
			am_q     <= am_d;
			mean_q   <= sum_neg ? $signed(-am_d) : $signed(am_d);
			acc_q    <= '0;
			mcand_q  <= AW'(am_d);
			mplier_q <= am_d;
		end else if (cmd.mul_load_n) begin
			acc_q    <= AW'(sq_q);
			mcand_q  <= acc_q;
			mplier_q <= MUL_W'(count_q);
		end else if (cmd.mul_load_x) begin
			mcand_q  <= AW'({sum_mag, 1'b0});
			mplier_q <= am_q;
		end else if (cmd.mul_step) begin
			if (mplier_q[0]) begin
				acc_q <= cmd.mul_sub ? acc_q - mcand_q : acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[AW-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[MUL_W-1:1]};
		end
	end

	// digit-by-digit square root, two radicand bits per cycle
	assign root_cur   = {rrem_q, rad_q[ROOT_IN_W-1 -: 2]};
	assign root_trial = RW'({root_q, 2'b01});

	always_ff @(posedge clk) begin
		if (cmd.root_load) begin
			rad_q      <= dvd_q[ROOT_IN_W-1:0];
			root_sat_q <= |dvd_q[AW-1:ROOT_IN_W];
			rrem_q     <= '0;
			root_q     <= '0;
		end else if (cmd.root_step) begin
			rad_q <= {rad_q[ROOT_IN_W-3:0], 2'b00};
			if (root_cur >= root_trial) begin
				rrem_q <= RREM_W'(root_cur - root_trial);
				root_q <= {root_q[STD_W-2:0], 1'b1};
			end else begin
				rrem_q <= root_cur[RREM_W-1:0];
				root_q <= {root_q[STD_W-2:0], 1'b0};
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_mean_q <= mean_q;
			res_std_q  <= root_sat_q ? {STD_W{1'b1}} : root_q;
			res_min_q  <= IN_W'(min_q);
			res_max_q  <= IN_W'(max_q);
			res_pp_q   <= $unsigned(IN_W'(max_q)) - $unsigned(IN_W'(min_q));
			res_ovf_q  <= drop_q;
		end
	end

	assign results.valid        = res_valid_q;
	assign results.mean         = res_mean_q;
	assign results.std_dev      = res_std_q;
	assign results.minimum      = res_min_q;
	assign results.maximum      = res_max_q;
	assign results.peak_to_peak = res_pp_q;
	assign results.overflow     = res_ovf_q;

`ifndef NO_ASSERTIONS
	a_drop_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !take |=> drop_q)
		else $error("dropped sample did not raise overflow");

	a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !res_valid_q || results.ready)
		else $error("pending result overwritten");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> res_valid_q)
		else $error("result not presented after emit");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && take_s1 |=> min_q <= max_q)
		else $error("minimum above maximum after a kept sample");

	a_no_intake_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step || cmd.mul_step || cmd.root_step |-> !accept && !valid_s1)
		else $error("sample taken during result computation");
`endif

endmodule

`default_nettype wire

// ===== rtl/waveform_statistics.sv =====
// Waveform statistics: samples are accepted one per cycle until the one
// flagged last; a sample beyond MAX_SAMPLES is dropped and sets overflow.
// After the last sample the block stops taking samples while it computes
// the result, and also while the previous result still sits untaken in the
// output register. It then loads one result transaction into the output
// register and opens the sample channel again, while that result waits to
// be taken. The time is set by the shared restoring divider (one quotient
// bit per cycle, used for the mean and for the variance), the shift-add
// multiplier (three passes for the sum of squared deviations) and the square
// root (two radicand bits per cycle). mean_divisor (byte address 0, reset
// 2048, a zero is taken as one) must be written over APB only between
// waveforms; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module waveform_statistics import wfs_pkg::*; #(
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  wire                   clk,
	input  wire                   arst_n,
	wfs_sample_if.sink            samples,
	wfs_result_if.source          results,
	input  wire                   psel,
	input  wire                   penable,
	input  wire                   pwrite,
	input  wire [PADDR_W-1:0]     paddr,
	input  wire [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [DIV_W-1:0]     div_q;
	logic [REG_IDX_W-1:0] reg_idx;
	cmd_t                 cmd;
	sts_t                 sts;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= DIV_RESET;
		end else if (psel && penable && pwrite && pready
				&& reg_idx == REG_MEAN_DIVISOR) begin
			div_q <= pwdata[DIV_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_MEAN_DIVISOR) begin
			prdata = APB_DATA_W'(div_q);
		end
	end

	wfs_ctrl #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.sts   (sts),
		.cmd   (cmd)
	);

	wfs_dpath #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.mean_divisor(div_q),
		.cmd         (cmd),
		.sts         (sts),
		.samples     (samples),
		.results     (results)
	);

endmodule

`default_nettype wire

// ===== tb/waveform_statistics_tb.sv =====
`timescale 1ns / 1ps

module waveform_statistics_tb;
	import wfs_pkg::*;

	localparam int MAX_SAMPLES = DEF_MAX_SAMPLES;
	localparam int CALC_CYCLES = 2 * ($clog2(MAX_SAMPLES + 1) + 63) + 135;
	localparam logic [PADDR_W-1:0] DIVISOR_ADDR = PADDR_W'(REG_MEAN_DIVISOR) << 2;
	localparam logic signed [IN_W-1:0] SAMPLE_TOP = {1'b0, {(IN_W - 1){1'b1}}};
	localparam logic signed [IN_W-1:0] SAMPLE_BOTTOM = {1'b1, {(IN_W - 1){1'b0}}};
	localparam logic signed [127:0] MEAN_CEIL = 128'sd2147483647;
	localparam logic signed [127:0] MEAN_FLOOR = -128'sd2147483648;
	localparam logic signed [127:0] ROOT_LIMIT = 128'sh3FFF_FFFF_FFFF_FFFF;
	localparam int RANDOM_SAMPLES = 560;
	localparam int PRINT_LIMIT = 40;

	typedef enum {KIND_FULL, KIND_SMALL, KIND_EXTREME} sample_kind_t;

	typedef struct {
		logic signed [MEAN_W-1:0] mean;
		logic [STD_W-1:0]         std_dev;
		logic signed [IN_W-1:0]   minimum;
		logic signed [IN_W-1:0]   maximum;
		logic [IN_W-1:0]          peak_to_peak;
		logic                     overflow;
	} stats_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [PADDR_W-1:0]    paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	wfs_sample_if samples_if ();
	wfs_result_if results_if ();

	waveform_statistics DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predictor state
	logic [DIV_W-1:0]       divisor_reg = DIV_RESET;
	int unsigned            wf_count = 0;
	logic signed [63:0]     wf_sum = '0;
	logic [63:0]            wf_sq = '0;
	logic signed [IN_W-1:0] wf_min = SAMPLE_TOP;
	logic signed [IN_W-1:0] wf_max = SAMPLE_BOTTOM;
	logic                   wf_dropped = 1'b0;

	stats_t pending_stats[$];

	int  mismatch_count = 0;
	int  samples_taken = 0;
	int  waveforms_sent = 0;
	int  results_checked = 0;
	int  divisor_writes = 0;
	int  hold_off_cycles = 0;
	int  stall_cycles = 0;
	bit  steady_flow = 1'b0;

	always #5 clk = ~clk;

	initial begin
		#30_000_000;
		$display("FAIL waveform_statistics");
		$finish;
	end

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
	endtask

	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 120);
	endfunction

	function automatic logic [STD_W-1:0] root_floor(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] trial;
		root = '0;
		for (int b = STD_W - 1; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= v)
				root = trial;
		end
		return root[STD_W-1:0];
	endfunction

	function automatic stats_t predict_statistics();
		logic signed [127:0] d_w;
		logic signed [127:0] s_w;
		logic signed [127:0] n_w;
		logic signed [127:0] m_w;
		logic signed [127:0] var_w;
		logic signed [127:0] q_w;
		stats_t want;
		d_w = (divisor_reg == '0) ? 128'sd1 : $signed({{(128 - DIV_W){1'b0}}, divisor_reg});
		s_w = 128'(wf_sum);
		n_w = $signed({96'd0, wf_count});
		m_w = s_w / d_w;
		if (m_w > MEAN_CEIL)
			m_w = MEAN_CEIL;
		if (m_w < MEAN_FLOOR)
			m_w = MEAN_FLOOR;
		// sum of squared deviations from the saturated mean
		var_w = $signed({64'd0, wf_sq}) + n_w * m_w * m_w - 128'sd2 * m_w * s_w;
		q_w = var_w / d_w;
		want.mean = m_w[MEAN_W-1:0];
		want.std_dev = (q_w > ROOT_LIMIT) ? {STD_W{1'b1}} : root_floor(q_w[63:0]);
		want.minimum = wf_min;
		want.maximum = wf_max;
		want.peak_to_peak = wf_max - wf_min;
		want.overflow = wf_dropped;
		return want;
	endfunction

	function automatic void accumulate_sample(input logic signed [IN_W-1:0] value,
		input bit is_last);
		logic signed [63:0] x;
		x = 64'(value);
		samples_taken++;
		if (wf_count >= MAX_SAMPLES) begin
			wf_dropped = 1'b1;
		end else begin
			wf_count++;
			wf_sum += x;
			wf_sq += x * x;
			if (value < wf_min)
				wf_min = value;
			if (value > wf_max)
				wf_max = value;
		end
		if (is_last) begin
			pending_stats.push_back(predict_statistics());
			waveforms_sent++;
			wf_count = 0;
			wf_sum = '0;
			wf_sq = '0;
			wf_min = SAMPLE_TOP;
			wf_max = SAMPLE_BOTTOM;
			wf_dropped = 1'b0;
		end
	endfunction

	task automatic send_sample(input logic signed [IN_W-1:0] value, input bit is_last);
		int gap;
		gap = steady_flow ? 0 : idle_cycles();
		@(negedge clk);
		if (gap > 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		samples_if.valid <= 1'b1;
		samples_if.sample <= value;
		samples_if.last <= is_last;
		do @(posedge clk); while (!samples_if.ready);
		accumulate_sample(value, is_last);
	endtask

	function automatic logic signed [IN_W-1:0] random_sample(input sample_kind_t kind);
		int v;
		case (kind)
			KIND_SMALL: begin
				v = $urandom_range(0, 64);
				return IN_W'(v - 32);
			end
			KIND_EXTREME: begin
				case ($urandom_range(0, 3))
					0: return SAMPLE_TOP;
					1: return SAMPLE_BOTTOM;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return IN_W'($urandom());
		endcase
	endfunction

	task automatic send_waveform(input int len, input sample_kind_t kind);
		for (int i = 0; i < len; i++)
			send_sample(random_sample(kind), i == len - 1);
	endtask

	// stop offering samples until every result is back and the block is idle
	task automatic settle_block();
		@(negedge clk);
		samples_if.valid <= 1'b0;
		while (pending_stats.size() != 0) @(posedge clk);
		repeat (CALC_CYCLES) @(posedge clk);
	endtask

	task automatic write_divisor(input logic [APB_DATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= DIVISOR_ADDR;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		divisor_reg = data[DIV_W-1:0];
		divisor_writes++;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic test_directed_cases();
		send_sample(SAMPLE_TOP, 1'b1);
		send_sample(SAMPLE_BOTTOM, 1'b1);
		send_sample('0, 1'b0);
		send_sample('1, 1'b0);
		send_sample(SAMPLE_TOP, 1'b0);
		send_sample(SAMPLE_BOTTOM, 1'b0);
		send_sample(24'h555555, 1'b0);
		send_sample(24'hAAAAAA, 1'b1);
		settle_block();
		write_divisor(32'd1);
		send_sample(24'sd1, 1'b0);
		send_sample(24'sd2, 1'b0);
		send_sample(24'sd3, 1'b0);
		send_sample(-24'sd7, 1'b1);
		settle_block();
		// zero divisor
		write_divisor(32'd0);
		send_sample(24'sd100, 1'b0);
		send_sample(-24'sd50, 1'b0);
		send_sample(24'sd7, 1'b1);
		settle_block();
		// divisor above nominal range
		write_divisor(32'd131071);
		send_sample(SAMPLE_TOP, 1'b0);
		send_sample(SAMPLE_TOP, 1'b1);
		settle_block();
		write_divisor(32'd65536);
		send_sample(SAMPLE_BOTTOM, 1'b0);
		send_sample(SAMPLE_BOTTOM, 1'b1);
		settle_block();
		// upper data bits ignored, negative mean truncates toward zero
		write_divisor(32'hFFFE_0003);
		send_sample(-24'sd5, 1'b0);
		send_sample(-24'sd2, 1'b1);
		settle_block();
	endtask

	task automatic test_output_stall();
		write_divisor(32'd4);
		hold_off_cycles = 6 * CALC_CYCLES;
		repeat (6) send_waveform($urandom_range(2, 12), sample_kind_t'($urandom_range(0, 2)));
		settle_block();
	endtask

	task automatic test_random_waveforms();
		int first_sample;
		int len;
		int pick;
		logic [APB_DATA_W-1:0] data;
		first_sample = samples_taken;
		while (samples_taken - first_sample < RANDOM_SAMPLES) begin
			settle_block();
			data = $urandom();
			case ($urandom_range(0, 9))
				0: data[DIV_W-1:0] = '0;
				1: data[DIV_W-1:0] = DIV_W'(1);
				2: data[DIV_W-1:0] = '1;
				3: data[DIV_W-1:0] = DIV_W'(65536);
				4: data[DIV_W-1:0] = DIV_W'(2048);
				5: data[DIV_W-1:0] = DIV_W'($urandom_range(2, 16));
				6: data[DIV_W-1:0] = DIV_W'($urandom_range(17, 65535));
				default: data[DIV_W-1:0] = DIV_W'($urandom_range(1, 300));
			endcase
			write_divisor(data);
			steady_flow = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(3, 8)) begin
				pick = $urandom_range(0, 99);
				if (pick < 75)
					len = $urandom_range(1, 16);
				else if (pick < 97)
					len = $urandom_range(17, 80);
				else
					len = $urandom_range(150, 320);
				send_waveform(len, sample_kind_t'($urandom_range(0, 2)));
			end
		end
		settle_block();
		steady_flow = 1'b0;
	endtask

	// result side: long hold-off on request, otherwise random stalls outside steady flow
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			results_if.ready <= 1'b0;
			hold_off_cycles--;
		end else if (stall_cycles > 0) begin
			results_if.ready <= 1'b0;
			stall_cycles--;
		end else begin
			results_if.ready <= 1'b1;
			if (!steady_flow && $urandom_range(0, 5) == 0)
				stall_cycles = idle_cycles();
		end
	end

	always @(posedge clk) begin
		stats_t got;
		stats_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			got.mean = results_if.mean;
			got.std_dev = results_if.std_dev;
			got.minimum = results_if.minimum;
			got.maximum = results_if.maximum;
			got.peak_to_peak = results_if.peak_to_peak;
			got.overflow = results_if.overflow;
			if (pending_stats.size() == 0) begin
				flag_mismatch("transaction with no waveform pending, mean", got.mean, 0);
			end else begin
				want = pending_stats.pop_front();
				results_checked++;
				if (got.mean !== want.mean)
					flag_mismatch("mean", got.mean, want.mean);
				if (got.std_dev !== want.std_dev)
					flag_mismatch("std_dev", got.std_dev, want.std_dev);
				if (got.minimum !== want.minimum)
					flag_mismatch("minimum", got.minimum, want.minimum);
				if (got.maximum !== want.maximum)
					flag_mismatch("maximum", got.maximum, want.maximum);
				if (got.peak_to_peak !== want.peak_to_peak)
					flag_mismatch("peak_to_peak", got.peak_to_peak, want.peak_to_peak);
				if (got.overflow !== want.overflow)
					flag_mismatch("overflow", got.overflow, want.overflow);
			end
		end
	end

	initial begin
		samples_if.valid = 1'b0;
		samples_if.sample = '0;
		samples_if.last = 1'b0;
		results_if.ready = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		test_directed_cases();
		test_output_stall();
		test_random_waveforms();
		settle_block();
		if (pending_stats.size() != 0)
			flag_mismatch("results never delivered", pending_stats.size(), 0);
		$display("covered %0d samples in %0d waveforms, %0d results compared",
			samples_taken, waveforms_sent, results_checked);
		$display("%0d divisor writes incl. zero and top of range, long output hold-off",
			divisor_writes);
		if (mismatch_count == 0) begin
			$display("PASS waveform_statistics");
		end else begin
			$display("FAIL waveform_statistics");
		end
		$finish;
	end

endmodule
